// ===== src/mac_learning_table_with_aging_unit_macros.svh =====
// Assertion macros shared by the address table RTL.
`ifndef MAC_LEARNING_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define MLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define MLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mlt_pkg.sv =====
// Types and constants shared by the address table modules.
package mlt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PORT_COUNT    = 16;
  localparam int STAMP_BITS    = 16;
  localparam int MAC_W         = 48;
  localparam int PORT_W        = 4;
  localparam int TIMEOUT_W     = 12;
  localparam int COUNT_W       = 7;
  localparam int COUNT_MAX     = 127;
  localparam int TIMEOUT_RESET = 30;

  // Removal counting: each group of cells is counted and registered, and the group counts are added in the next cycle.
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PART_W     = $clog2(GROUP_SIZE + 1);
  localparam int SUM_W      = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_LEARN  = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NOP    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY,
    ST_SUM
  } state_t;

  typedef struct packed {
    req_kind_t         req_type;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port_in;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [PORT_W-1:0]  port_out;
    logic [COUNT_W-1:0] removed_count;
    logic               learn_dropped;
  } rsp_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                  capture;
    logic                  learn_go;
    logic                  tick_go;
    logic                  found;
    logic [MAC_W-1:0]      mac;
    logic [PORT_W-1:0]     port;
    logic [STAMP_BITS-1:0] stamp;
    logic [TIMEOUT_W-1:0]  timeout;
  } cell_ctl_t;

  // Status flags that each cell reports back.
  typedef struct packed {
    logic valid;
    logic match;
    logic expire;
  } cell_stat_t;

endpackage

// ===== src/mlt_cell.sv =====
// One table entry with its address compare, age check and free-slot chain link.
module mlt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  mlt_pkg::cell_ctl_t            ctl,
  input  logic                          free_in,
  output logic                          free_out,
  input  logic [mlt_pkg::PORT_W-1:0]    pchain_in,
  output logic [mlt_pkg::PORT_W-1:0]    pchain_out,
  output mlt_pkg::cell_stat_t           stat
);

  logic                              valid;
  logic                              match;
  logic                              expire;
  logic [mlt_pkg::MAC_W-1:0]         address;
  logic [mlt_pkg::PORT_W-1:0]        port;
  logic [mlt_pkg::STAMP_BITS-1:0]    stamp;
  logic [mlt_pkg::STAMP_BITS-1:0]    age;
  logic                              take;

  // Age wraps with the stamp width.
  assign age = ctl.stamp - stamp;

  // This cell takes a new address when nothing matched, this cell is free and no lower cell is free.
  assign take = !ctl.found && !valid && !free_in;

  // Chain links toward the next cell.
  assign free_out   = free_in | ~valid;
  assign pchain_out = pchain_in | (match ? port : '0);

  assign stat.valid  = valid;
  assign stat.match  = match;
  assign stat.expire = expire;

  // Control flags: valid bit and the flags captured in the compare cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      match  <= 1'b0;
      expire <= 1'b0;
    end else begin
      if (ctl.capture) begin
        match  <= valid && (address == ctl.mac);
        expire <= valid && (age >= mlt_pkg::STAMP_BITS'(ctl.timeout));
      end
      if (ctl.tick_go && expire) begin
        valid <= 1'b0;
      end else if (ctl.learn_go && take) begin
        valid <= 1'b1;
      end
    end
  end

  // Entry payload, written by a learn that refreshes or fills this cell.
  always_ff @(posedge clk) begin
    if (ctl.learn_go && (match || take)) begin
      port  <= ctl.port;
      stamp <= ctl.stamp;
      if (take) begin
        address <= ctl.mac;
      end
    end
  end

endmodule

// ===== src/mlt_count.sv =====
// Two-step count of the entries that a tick removes.
module mlt_count (
  input  logic                               clk,
  input  logic                               load,
  input  logic [mlt_pkg::TABLE_ENTRIES-1:0]  expire_vec,
  output logic [mlt_pkg::COUNT_W-1:0]        removed
);

  logic [mlt_pkg::PART_W-1:0] part      [mlt_pkg::GROUPS];
  logic [mlt_pkg::PART_W-1:0] part_next [mlt_pkg::GROUPS];
  logic [mlt_pkg::SUM_W-1:0]  sum;

  // Count each group of cells.
  always_comb begin
    for (int g = 0; g < mlt_pkg::GROUPS; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < mlt_pkg::GROUP_SIZE; k++) begin
        if (g * mlt_pkg::GROUP_SIZE + k < mlt_pkg::TABLE_ENTRIES) begin
          part_next[g] = part_next[g]
                         + mlt_pkg::PART_W'(expire_vec[g * mlt_pkg::GROUP_SIZE + k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part <= part_next;
    end
  end

  // Add the group counts and saturate to the result field.
  always_comb begin
    sum = '0;
    for (int g = 0; g < mlt_pkg::GROUPS; g++) begin
      sum = sum + mlt_pkg::SUM_W'(part[g]);
    end
    if (int'(sum) > mlt_pkg::COUNT_MAX) begin
      removed = mlt_pkg::COUNT_W'(mlt_pkg::COUNT_MAX);
    end else begin
      removed = mlt_pkg::COUNT_W'(sum);
    end
  end

endmodule

// ===== src/mac_learning_table_with_aging_unit.sv =====
// A new request is accepted only in the idle state; a tick also passes through the sum step.
// The done strobe is registered from the apply step for lookup and learn, and from the sum step for a tick.
// Cycles: capture the request, compare in every cell, apply along the cell chain, sum (tick).
// The free-slot and port chains ripple through all cells in the apply cycle.
// Synchronous reset clears all entries, the seconds counter and sets the timeout to 30.
`include "mac_learning_table_with_aging_unit_macros.svh"

module mac_learning_table_with_aging_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  mlt_pkg::req_t                    req,
  output logic                             done,
  output mlt_pkg::rsp_t                    rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mlt_pkg::TIMEOUT_W-1:0]    cfg_data
);

  mlt_pkg::state_t                     state;
  mlt_pkg::state_t                     state_next;
  mlt_pkg::req_t                       req_q;
  logic [mlt_pkg::TIMEOUT_W-1:0]       aging_timeout;
  logic [mlt_pkg::STAMP_BITS-1:0]      seconds_now;
  mlt_pkg::cell_ctl_t                  ctl;
  mlt_pkg::cell_stat_t                 stat [mlt_pkg::TABLE_ENTRIES];
  logic                                free_c  [mlt_pkg::TABLE_ENTRIES+1];
  logic [mlt_pkg::PORT_W-1:0]          pchain  [mlt_pkg::TABLE_ENTRIES+1];
  logic [mlt_pkg::TABLE_ENTRIES-1:0]   match_vec;
  logic [mlt_pkg::TABLE_ENTRIES-1:0]   expire_vec;
  logic [mlt_pkg::TABLE_ENTRIES-1:0]   valid_vec;
  logic [mlt_pkg::COUNT_W-1:0]         removed;
  logic                                found;
  logic                                port_ok;
  logic                                accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign port_ok   = int'(req_q.port_in) < mlt_pkg::PORT_COUNT;
  assign found     = |match_vec;

  // Request capture, timeout register and seconds counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      aging_timeout <= mlt_pkg::TIMEOUT_W'(mlt_pkg::TIMEOUT_RESET);
      seconds_now   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        aging_timeout <= cfg_data;
      end
      if (accept && req.req_type == mlt_pkg::REQ_TICK) begin
        seconds_now <= seconds_now + mlt_pkg::STAMP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the control broadcast to the cells.
  always_comb begin
    state_next   = state;
    busy         = 1'b1;
    ctl.capture  = 1'b0;
    ctl.learn_go = 1'b0;
    ctl.tick_go  = 1'b0;
    ctl.found    = found;
    ctl.mac      = req_q.mac;
    ctl.port     = req_q.port_in;
    ctl.stamp    = seconds_now;
    ctl.timeout  = aging_timeout;
    unique case (state)
      mlt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = mlt_pkg::ST_CMP;
        end
      end
      mlt_pkg::ST_CMP: begin
        ctl.capture = 1'b1;
        state_next  = mlt_pkg::ST_APPLY;
      end
      mlt_pkg::ST_APPLY: begin
        ctl.learn_go = (req_q.req_type == mlt_pkg::REQ_LEARN) && port_ok;
        ctl.tick_go  = (req_q.req_type == mlt_pkg::REQ_TICK);
        state_next   = (req_q.req_type == mlt_pkg::REQ_TICK) ? mlt_pkg::ST_SUM
                                                             : mlt_pkg::ST_IDLE;
      end
      mlt_pkg::ST_SUM: begin
        state_next = mlt_pkg::ST_IDLE;
      end
      default: begin
        state_next = mlt_pkg::ST_IDLE;
      end
    endcase
  end

  // The row of entry cells, chained from entry 0 upward.
  assign free_c[0] = 1'b0;
  assign pchain[0] = '0;

  for (genvar i = 0; i < mlt_pkg::TABLE_ENTRIES; i++) begin : g_cell
    mlt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .free_in    (free_c[i]),
      .free_out   (free_c[i+1]),
      .pchain_in  (pchain[i]),
      .pchain_out (pchain[i+1]),
      .stat       (stat[i])
    );
    assign match_vec[i]  = stat[i].match;
    assign expire_vec[i] = stat[i].expire;
    assign valid_vec[i]  = stat[i].valid;
  end

  mlt_count u_count (
    .clk        (clk),
    .load       (state == mlt_pkg::ST_APPLY),
    .expire_vec (expire_vec),
    .removed    (removed)
  );

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == mlt_pkg::ST_SUM)
              || (state == mlt_pkg::ST_APPLY && req_q.req_type != mlt_pkg::REQ_TICK);
    end
  end

  // Result transaction payload.
  always_ff @(posedge clk) begin
    if (state == mlt_pkg::ST_APPLY) begin
      rsp.hit           <= (req_q.req_type == mlt_pkg::REQ_LOOKUP) && found;
      rsp.port_out      <= ((req_q.req_type == mlt_pkg::REQ_LOOKUP) && found)
                           ? pchain[mlt_pkg::TABLE_ENTRIES] : '0;
      rsp.removed_count <= '0;
      rsp.learn_dropped <= (req_q.req_type == mlt_pkg::REQ_LEARN) && port_ok && !found
                           && !free_c[mlt_pkg::TABLE_ENTRIES];
    end else if (state == mlt_pkg::ST_SUM) begin
      rsp.removed_count <= removed;
    end
  end

  `MLT_ASSERT_IMP(a_unique_match, state == mlt_pkg::ST_APPLY, $onehot0(match_vec), "address held by more than one entry")
  `MLT_ASSERT_NXT(a_accept_busy, accept, busy && !done, "accepted request did not make the unit busy")
  `MLT_ASSERT_IMP(a_done_origin, done, $past(state) == mlt_pkg::ST_APPLY || $past(state) == mlt_pkg::ST_SUM, "result strobe outside the apply or sum step")
  `MLT_ASSERT_IMP(a_drop_full, done && rsp.learn_dropped, $past(&valid_vec), "learn dropped while a free entry existed")

endmodule
